// File: rtl/su8v_pkg.sv
// ----------------------------------------------------------------------------
// su8v_pkg
// Shared types and constants of the strict utf-8 validator.
// ----------------------------------------------------------------------------
package su8v_pkg;

  localparam int unsigned ScalarW = 21;

  // sequence length class, sets the smallest scalar that is not overlong
  localparam logic [1:0] LenNone = 2'd0;
  localparam logic [1:0] Len2B   = 2'd1;
  localparam logic [1:0] Len3B   = 2'd2;
  localparam logic [1:0] Len4B   = 2'd3;

  localparam logic [7:0] AsciiSpace = 8'h20;
  localparam logic [7:0] AsciiDel   = 8'h7F;
  localparam logic [7:0] LeadMin2B  = 8'hC2;
  localparam logic [7:0] LeadMax2B  = 8'hDF;
  localparam logic [7:0] LeadMin3B  = 8'hE0;
  localparam logic [7:0] LeadMax3B  = 8'hEF;
  localparam logic [7:0] LeadMin4B  = 8'hF0;
  localparam logic [7:0] LeadMax4B  = 8'hF4;

  localparam logic [ScalarW-1:0] ScalarMax    = 21'h10FFFF;
  localparam logic [ScalarW-1:0] Min2B        = 21'h000080;
  localparam logic [ScalarW-1:0] Min3B        = 21'h000800;
  localparam logic [ScalarW-1:0] Min4B        = 21'h010000;
  localparam logic [ScalarW-1:0] SurrLo       = 21'h00D800;
  localparam logic [ScalarW-1:0] SurrHi       = 21'h00DFFF;
  localparam logic [ScalarW-1:0] C1Lo         = 21'h000080;
  localparam logic [ScalarW-1:0] C1Hi         = 21'h00009F;
  localparam logic [ScalarW-1:0] NonCharLo    = 21'h00FDD0;
  localparam logic [ScalarW-1:0] NonCharHi    = 21'h00FDEF;
  localparam logic [15:0]        PlaneEndLo   = 16'hFFFE;
  localparam logic [ScalarW-1:0] LineSep      = 21'h002028;
  localparam logic [ScalarW-1:0] ParaSep      = 21'h002029;

  typedef struct packed {
    logic [1:0]         pending;
    logic [ScalarW-1:0] accum;
    logic [1:0]         len_class;
    logic               failed;
  } dec_state_t;

endpackage

// File: rtl/strict_utf8_validator.sv
// ----------------------------------------------------------------------------
// strict_utf8_validator
// Strict utf-8 string checker, one byte per transfer, one verdict per string.
// ----------------------------------------------------------------------------
// channel   dir  tdata                  tlast      tuser
// s_axis    in   [7:0] data_byte        is_final   -
// m_axis    out  [0] valid_res, [7:1] 0 -          -
//
// one byte per cycle unless a final byte waits on a stalled result; a verdict
// is offered from the result register, after the final byte has passed the input
// register and the decode. the throughput is set by the decode step on the state
// register. reset clears both valid flags and the decode state.
// a stalled result blocks only the next final byte, which waits in the input
// register and holds off the input; the bytes before it keep flowing.
module strict_utf8_validator
  import su8v_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // is_final
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [0] valid_res, [7:1] zero
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q, out_valid_d;
  logic       out_res_q;
  logic       out_free;
  logic       adv;
  logic       take_in;
  dec_state_t st_q, st_d;
  logic       verdict;

  su8v_decode u_decode (
    .state_i   (st_q),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .state_o   (st_d),
    .verdict_o (verdict)
  );

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign adv             = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_valid_q || adv;
  assign take_in         = s_axis_tvalid_i && s_axis_tready_o;

  assign in_valid_d  = take_in || (in_valid_q && !adv);
  assign out_valid_d = (adv && in_last_q) || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (adv && in_last_q) begin
      out_res_q <= verdict;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_res_q};

  // state is cleared after every verdict
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_last_q) |=> (st_q == '0))
    else $error("decode state not cleared after final byte");

  // an error stays until the final byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.failed && !(adv && in_last_q)) |=> st_q.failed)
    else $error("sticky error flag dropped mid-string");

  // a new result comes only from a final byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(adv && in_last_q))
    else $error("result without a final byte");

  // a final byte never overwrites a result still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !(adv && in_last_q))
    else $error("final byte processed over a pending result");

endmodule

// File: rtl/su8v_decode.sv
// ----------------------------------------------------------------------------
// su8v_decode
// Combinational byte step: lead/continuation decode, scalar checks, verdict.
// ----------------------------------------------------------------------------
module su8v_decode
  import su8v_pkg::*;
(
  input  dec_state_t  state_i,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  output dec_state_t  state_o,
  output logic        verdict_o
);

  dec_state_t         upd;
  logic [ScalarW-1:0] cp;
  logic [ScalarW-1:0] cp_min;
  logic               cp_ok;

  assign cp = {state_i.accum[ScalarW-7:0], byte_i[5:0]};

  always_comb begin
    case (state_i.len_class)
      Len2B:   cp_min = Min2B;
      Len3B:   cp_min = Min3B;
      default: cp_min = Min4B;
    endcase
  end

  assign cp_ok = (cp >= cp_min) && (cp <= ScalarMax)
              && !((cp >= SurrLo) && (cp <= SurrHi))
              && !((cp >= C1Lo) && (cp <= C1Hi))
              && !((cp >= NonCharLo) && (cp <= NonCharHi))
              && !(cp[15:0] >= PlaneEndLo)
              && (cp != LineSep) && (cp != ParaSep);

  always_comb begin
    upd = state_i;
    if (!state_i.failed) begin
      if (state_i.pending == 2'd0) begin
        if (!byte_i[7]) begin
          if ((byte_i < AsciiSpace) || (byte_i == AsciiDel)) begin
            upd.failed = 1'b1;
          end
        end else if ((byte_i >= LeadMin2B) && (byte_i <= LeadMax2B)) begin
          upd.pending   = 2'd1;
          upd.accum     = {16'd0, byte_i[4:0]};
          upd.len_class = Len2B;
        end else if ((byte_i >= LeadMin3B) && (byte_i <= LeadMax3B)) begin
          upd.pending   = 2'd2;
          upd.accum     = {17'd0, byte_i[3:0]};
          upd.len_class = Len3B;
        end else if ((byte_i >= LeadMin4B) && (byte_i <= LeadMax4B)) begin
          upd.pending   = 2'd3;
          upd.accum     = {18'd0, byte_i[2:0]};
          upd.len_class = Len4B;
        end else begin
          upd.failed = 1'b1;
        end
      end else if (byte_i[7:6] != 2'b10) begin
        upd.failed = 1'b1;
      end else begin
        upd.accum   = cp;
        upd.pending = state_i.pending - 2'd1;
        // checks apply once the last continuation byte is in
        if ((state_i.pending == 2'd1) && !cp_ok) begin
          upd.failed = 1'b1;
        end
      end
    end
  end

  assign verdict_o = !upd.failed && (upd.pending == 2'd0);
  assign state_o   = last_i ? '0 : upd;

endmodule

// File: tb/sv/strict_utf8_validator_tb.sv
// ----------------------------------------------------------------------------
// strict_utf8_validator_tb
// Drives byte strings into the validator: a short table of corner cases, then
// random strings, mostly well formed with targeted bad scalars and noise. Each
// verdict is checked against its typed value or a local decoder model; both
// stream sides idle at random; the result side once holds off for a long time.
// ----------------------------------------------------------------------------
module strict_utf8_validator_tb;
  import su8v_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomBytes    = 900;
  localparam int unsigned CalmBytes      = 120;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned DrainCycles    = 8;
  localparam int unsigned CycleLimit     = 200_000;
  localparam int unsigned DirCount       = 27;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       known;    // verdict column is valid for this row
    logic       verdict;
  } stim_row_t;

  // corner strings; verdicts typed in only where they are obvious
  localparam stim_row_t DirRows [DirCount] = '{
    '{8'h20, 1'b0, 1'b0, 1'b0}, '{8'h7E, 1'b1, 1'b1, 1'b1},  // printable edges
    '{8'h7F, 1'b1, 1'b1, 1'b0},                              // del
    '{8'hFF, 1'b1, 1'b1, 1'b0},                              // invalid lead
    '{8'hC2, 1'b1, 1'b1, 1'b0},                              // cut short
    '{8'h00, 1'b0, 1'b0, 1'b0}, '{8'h41, 1'b1, 1'b1, 1'b0},  // sticky control
    '{8'hC3, 1'b0, 1'b0, 1'b0}, '{8'h41, 1'b1, 1'b0, 1'b0},  // bad continuation
    '{8'hC2, 1'b0, 1'b0, 1'b0}, '{8'h80, 1'b1, 1'b0, 1'b0},  // c1 control
    '{8'hE0, 1'b0, 1'b0, 1'b0}, '{8'h80, 1'b0, 1'b0, 1'b0},  // overlong
    '{8'h80, 1'b1, 1'b0, 1'b0},
    '{8'hED, 1'b0, 1'b0, 1'b0}, '{8'hA0, 1'b0, 1'b0, 1'b0},  // surrogate
    '{8'h80, 1'b1, 1'b0, 1'b0},
    '{8'hF4, 1'b0, 1'b0, 1'b0}, '{8'h90, 1'b0, 1'b0, 1'b0},  // above 10ffff
    '{8'h80, 1'b0, 1'b0, 1'b0}, '{8'h80, 1'b1, 1'b0, 1'b0},
    '{8'hE2, 1'b0, 1'b0, 1'b0}, '{8'h80, 1'b0, 1'b0, 1'b0},  // paragraph sep
    '{8'hA9, 1'b1, 1'b0, 1'b0},
    '{8'hEF, 1'b0, 1'b0, 1'b0}, '{8'hBF, 1'b0, 1'b0, 1'b0},  // uffff
    '{8'hBF, 1'b1, 1'b0, 1'b0}
  };

  logic       clk_i;
  logic       rst_ni          = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i  = 8'h00;   // [7:0] data_byte
  logic       s_axis_tlast_i  = 1'b0;    // is_final
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;            // [0] valid_res, [7:1] zero

  dec_state_t  dec_st     = '0;
  logic        verdict_q[$];
  int unsigned bytes_sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt  = 0;
  bit          calm       = 1'b0;
  bit          hold_armed = 1'b0;
  bit          hold_done  = 1'b0;

  strict_utf8_validator uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic scalar_permitted(logic [ScalarW-1:0] cp, logic [1:0] cls);
    logic [ScalarW-1:0] min_cp;
    case (cls)
      Len2B:   min_cp = Min2B;
      Len3B:   min_cp = Min3B;
      default: min_cp = Min4B;
    endcase
    if (cp < min_cp || cp > ScalarMax) return 1'b0;
    if (cp >= SurrLo && cp <= SurrHi) return 1'b0;
    if (cp >= C1Lo && cp <= C1Hi) return 1'b0;
    if (cp >= NonCharLo && cp <= NonCharHi) return 1'b0;
    if (cp[15:0] >= PlaneEndLo) return 1'b0;
    if (cp == LineSep || cp == ParaSep) return 1'b0;
    return 1'b1;
  endfunction

  // advances the decoder by one byte, returns the verdict as of this byte
  function automatic logic decode_byte(logic [7:0] b, logic last);
    logic verdict;
    if (!dec_st.failed) begin
      if (dec_st.pending == 2'd0) begin
        if (!b[7]) begin
          if (b < AsciiSpace || b == AsciiDel) dec_st.failed = 1'b1;
        end else if (b >= LeadMin2B && b <= LeadMax2B) begin
          dec_st.pending   = 2'd1;
          dec_st.accum     = ScalarW'(b[4:0]);
          dec_st.len_class = Len2B;
        end else if (b >= LeadMin3B && b <= LeadMax3B) begin
          dec_st.pending   = 2'd2;
          dec_st.accum     = ScalarW'(b[3:0]);
          dec_st.len_class = Len3B;
        end else if (b >= LeadMin4B && b <= LeadMax4B) begin
          dec_st.pending   = 2'd3;
          dec_st.accum     = ScalarW'(b[2:0]);
          dec_st.len_class = Len4B;
        end else begin
          dec_st.failed = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        dec_st.failed = 1'b1;
      end else begin
        dec_st.accum   = {dec_st.accum[ScalarW-7:0], b[5:0]};
        dec_st.pending = dec_st.pending - 2'd1;
        if (dec_st.pending == 2'd0 && !scalar_permitted(dec_st.accum, dec_st.len_class))
          dec_st.failed = 1'b1;
      end
    end
    verdict = !dec_st.failed && dec_st.pending == 2'd0;
    if (last) dec_st = '0;
    return verdict;
  endfunction

  task automatic send_byte(input logic [7:0] data, input logic last,
                           input logic known, input logic verdict);
    logic model_v;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    model_v = decode_byte(data, last);
    if (last) verdict_q.push_back(known ? verdict : model_v);
    bytes_sent++;
  endtask

  task automatic append_scalar(input logic [ScalarW-1:0] cp, input int n,
                               ref logic [7:0] q[$]);
    case (n)
      1: q.push_back({1'b0, cp[6:0]});
      2: begin
        q.push_back({3'b110, cp[10:6]});
        q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        q.push_back({4'b1110, cp[15:12]});
        q.push_back({2'b10, cp[11:6]});
        q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        q.push_back({5'b11110, cp[20:18]});
        q.push_back({2'b10, cp[17:12]});
        q.push_back({2'b10, cp[11:6]});
        q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // one string of 1..6 characters, mostly legal scalars with some bad ones
  task automatic send_random_string();
    logic [7:0]         str_q[$];
    logic [ScalarW-1:0] cp;
    int                 n;
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: str_q.push_back(8'($urandom_range(32, 126)));
        6, 7:   append_scalar(ScalarW'($urandom_range(32'hA0, 32'h7FF)), 2, str_q);
        8, 9:   append_scalar(ScalarW'($urandom_range(32'h800, 32'hFFFF)), 3, str_q);
        10, 11: append_scalar(ScalarW'($urandom_range(32'h10000, 32'h10FFFF)), 4, str_q);
        12: begin
          case ($urandom_range(0, 2))
            0:       cp = ScalarW'($urandom_range(32'hFDCF, 32'hFDF0));
            1:       cp = ScalarW'(($urandom_range(0, 16) << 16) |
                                   $urandom_range(32'hFFFD, 32'hFFFF));
            default: cp = ScalarW'($urandom_range(32'h2027, 32'h202A));
          endcase
          append_scalar(cp, (cp < Min4B) ? 3 : 4, str_q);
        end
        13: begin
          if ($urandom_range(0, 1) == 0)
            append_scalar(ScalarW'($urandom_range(32'hD7FF, 32'hE000)), 3, str_q);
          else
            append_scalar(ScalarW'($urandom_range(32'h7F, 32'hA0)), 2, str_q);
        end
        14: begin
          // overlong: scalar below the floor of its length
          n = $urandom_range(2, 4);
          case (n)
            2:       cp = ScalarW'($urandom_range(0, 32'h7F));
            3:       cp = ScalarW'($urandom_range(0, 32'h7FF));
            default: cp = ScalarW'($urandom_range(0, 32'hFFFF));
          endcase
          append_scalar(cp, n, str_q);
        end
        15: append_scalar(ScalarW'($urandom_range(32'h110000, 32'h1FFFFF)), 4, str_q);
        16: begin
          case ($urandom_range(0, 5))
            0:       append_scalar(Min2B, 2, str_q);
            1:       append_scalar(Min3B - 1, 2, str_q);
            2:       append_scalar(Min3B, 3, str_q);
            3:       append_scalar(21'h00FFFD, 3, str_q);
            4:       append_scalar(Min4B, 4, str_q);
            default: append_scalar(21'h10FFFD, 4, str_q);
          endcase
        end
        17: str_q.push_back(($urandom_range(0, 4) == 0) ? AsciiDel
                                                        : 8'($urandom_range(0, 31)));
        18: str_q.push_back(8'($urandom_range(0, 255)));
        default: begin
          // multi-byte scalar cut short
          n = $urandom_range(2, 4);
          case (n)
            2:       cp = ScalarW'($urandom_range(32'hA0, 32'h7FF));
            3:       cp = ScalarW'($urandom_range(32'h800, 32'hFFFF));
            default: cp = ScalarW'($urandom_range(32'h10000, 32'h10FFFF));
          endcase
          append_scalar(cp, n, str_q);
          repeat ($urandom_range(1, n - 1)) void'(str_q.pop_back());
        end
      endcase
    end
    foreach (str_q[i]) send_byte(str_q[i], i == str_q.size() - 1, 1'b0, 1'b0);
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DirRows[i])
      send_byte(DirRows[i].data, DirRows[i].last, DirRows[i].known, DirRows[i].verdict);
    hold_armed = 1'b1;
    while (bytes_sent < DirCount + RandomBytes) begin
      if (bytes_sent + CalmBytes >= DirCount + RandomBytes) calm = 1'b1;
      send_random_string();
    end
    s_axis_tvalid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("strict_utf8_validator_tb passed");
    end else begin
      $display("strict_utf8_validator_tb failed");
    end
    $finish;
  end

  // result side: short random stalls, one long hold so the input backs up
  initial begin : sink
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : verdict_check
    logic want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected verdict transfer: valid_res actual %0b", m_axis_tdata_o[0]);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tdata_o[0] !== want) begin
          $error("valid_res mismatch: expected %0b, actual %0b", want, m_axis_tdata_o[0]);
          mismatches++;
        end
        if (m_axis_tdata_o[7:1] !== 7'd0) begin
          $error("pad mismatch: expected 0, actual %0h", m_axis_tdata_o[7:1]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("strict_utf8_validator_tb failed");
      $finish;
    end
  end

endmodule

// File: sim.f
rtl/su8v_pkg.sv
rtl/su8v_decode.sv
rtl/strict_utf8_validator.sv
tb/sv/strict_utf8_validator_tb.sv
